[hw/rtl/mcbc_pkg.sv]
// Shared types and constants for the mip chain budget cursor.
package mcbc_pkg;

  localparam int unsigned SideW    = 15;  // width of a configured side
  localparam int unsigned LvlW     = 4;   // level cursor and level count
  localparam int unsigned BudgetW  = 32;
  localparam int unsigned SpentW   = BudgetW + 1;
  localparam int unsigned RowOutW  = 13;
  localparam int unsigned ProdW    = 2 * SideW;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned DefaultMaxDimension = 16384;
  localparam int unsigned DefaultMinLevelSide = 4;

  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 1'b1;

  localparam logic OpAdvance = 1'b0;  // walk the cursor within the budget
  localparam logic OpReset   = 1'b1;  // cursor back to level 0, row 0

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEVEL,
    S_AREA,
    S_CMP,
    S_DIV,
    S_QSEL,
    S_APPLY,
    S_COMMIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;      // item accepted
    logic setup;     // latch level geometry, start area product
    logic area;      // charge area, start row cost product
    logic cmp;       // pick rows directly or seed the divider
    logic div_step;  // one quotient bit
    logic qsel;      // rows from quotient
    logic apply;     // row cost product
    logic commit;    // update cursor and spent
    logic res_load;  // capture result
  } cmd_t;

  typedef struct packed {
    logic lvl_ok;    // level cursor below level count
    logic need_div;  // budget covers only part of the level
    logic div_last;  // final divider step
    logic walk_end;  // spent reaches budget after this commit
  } status_t;

endpackage

[hw/rtl/mcbc_ctrl.sv]
// Sequencer for the level walk of the mip chain budget cursor.
module mcbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                op_i,
  input  mcbc_pkg::status_t   status_i,
  output mcbc_pkg::cmd_t      cmd_o,
  output logic                busy
);

  mcbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcbc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mcbc_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == mcbc_pkg::OpReset) ? mcbc_pkg::S_DONE : mcbc_pkg::S_LEVEL;
        end
      end
      mcbc_pkg::S_LEVEL: begin
        if (status_i.lvl_ok) begin
          cmd_o.setup = 1'b1;
          state_d     = mcbc_pkg::S_AREA;
        end else begin
          state_d = mcbc_pkg::S_DONE;
        end
      end
      mcbc_pkg::S_AREA: begin
        cmd_o.area = 1'b1;
        state_d    = mcbc_pkg::S_CMP;
      end
      mcbc_pkg::S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = status_i.need_div ? mcbc_pkg::S_DIV : mcbc_pkg::S_APPLY;
      end
      mcbc_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = mcbc_pkg::S_QSEL;
        end
      end
      mcbc_pkg::S_QSEL: begin
        cmd_o.qsel = 1'b1;
        state_d    = mcbc_pkg::S_APPLY;
      end
      mcbc_pkg::S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = mcbc_pkg::S_COMMIT;
      end
      mcbc_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = status_i.walk_end ? mcbc_pkg::S_DONE : mcbc_pkg::S_LEVEL;
      end
      mcbc_pkg::S_DONE: begin
        cmd_o.res_load = 1'b1;
        state_d        = mcbc_pkg::S_IDLE;
      end
      default: begin
        state_d = mcbc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != mcbc_pkg::S_IDLE);

endmodule

[hw/rtl/mcbc_datapath.sv]
// Registers, level geometry, multipliers and restoring divider of the cursor.
module mcbc_datapath #(
  parameter int unsigned MAX_DIMENSION  = mcbc_pkg::DefaultMaxDimension,
  parameter int unsigned MIN_LEVEL_SIDE = mcbc_pkg::DefaultMinLevelSide
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcbc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mcbc_pkg::SideW-1:0]          cfg_data_i,
  input  logic                                op_i,
  input  logic [mcbc_pkg::BudgetW-1:0]        budget_pixels_i,
  input  mcbc_pkg::cmd_t                      cmd_i,
  output mcbc_pkg::status_t                   status_o,
  output logic                                done_o,
  output logic [mcbc_pkg::LvlW-1:0]           level_index_o,
  output logic [mcbc_pkg::RowOutW-1:0]        row_index_o,
  output logic                                work_remains_o,
  output logic [mcbc_pkg::BudgetW-1:0]        pixels_spent_o
);

  localparam int unsigned SideW    = mcbc_pkg::SideW;
  localparam int unsigned SideMax  = (1 << SideW) - 1;
  localparam int unsigned ClampMax = (MAX_DIMENSION < SideMax) ? MAX_DIMENSION : SideMax;
  localparam int unsigned RowW     = (ClampMax / 2 > 1) ? $clog2(ClampMax / 2) : 1;
  localparam int unsigned CntW     = $clog2(SideW);
  localparam int unsigned DimW     = SideW + 2;
  localparam logic [DimW-1:0]      MaxDim  = DimW'(MAX_DIMENSION);
  localparam logic [SideW-1:0]     MinSide = SideW'(MIN_LEVEL_SIDE);
  localparam logic [CntW-1:0]      CntLast = CntW'(SideW - 1);

  logic [SideW-1:0] src_w_q, src_h_q;
  logic [mcbc_pkg::LvlW-1:0] lvl_q;
  logic [RowW-1:0] row_q;
  logic [mcbc_pkg::BudgetW-1:0] budget_q;
  logic [mcbc_pkg::SpentW-1:0] spent_q;
  logic [SideW-1:0] ow_q, oh_q, left_q, take_q, rem_q, dvd_q, quo_q;
  logic [mcbc_pkg::ProdW-1:0] area_q, prod_q, cost_q;
  logic [CntW-1:0] cnt_q;
  logic done_q, wr_q;
  logic [mcbc_pkg::LvlW-1:0] lvl_out_q;
  logic [mcbc_pkg::RowOutW-1:0] row_out_q;
  logic [mcbc_pkg::BudgetW-1:0] spent_out_q;

  // clamped sides and level count
  logic [SideW-1:0] w, h, lw, lh, ow, oh, left;
  logic [SideW-1:0] lvl_flags;
  logic [mcbc_pkg::LvlW-1:0] levels;
  logic [SideW-1:0] row_wide;

  assign w = ({2'b00, src_w_q} > MaxDim) ? MaxDim[SideW-1:0] : src_w_q;
  assign h = ({2'b00, src_h_q} > MaxDim) ? MaxDim[SideW-1:0] : src_h_q;

  always_comb begin
    for (int k = 0; k < SideW; k++) begin
      lvl_flags[k] = ((w >> k) >= MinSide) && ((h >> k) >= MinSide);
    end
  end
  assign levels = mcbc_pkg::LvlW'($countones(lvl_flags));

  assign lw       = w >> lvl_q;
  assign lh       = h >> lvl_q;
  assign ow       = lw >> 1;
  assign oh       = lh >> 1;
  assign row_wide = SideW'(row_q);
  assign left     = (oh > row_wide) ? oh - row_wide : '0;

  // remaining budget and row selection
  logic over;
  logic [mcbc_pkg::BudgetW-1:0] remain;
  assign over   = spent_q >= {1'b0, budget_q};
  assign remain = budget_q - spent_q[mcbc_pkg::BudgetW-1:0];

  // for zero-width rows the budget is divided by 1 instead of 0; such rows cost nothing
  logic [SideW-1:0] ow_div;
  assign ow_div = (ow_q != '0) ? ow_q : SideW'(1);

  // one restoring divider step
  logic [SideW:0] trial;
  logic           ge;
  logic [SideW:0] trial_sub;
  assign trial     = {rem_q, dvd_q[SideW-1]};
  assign ge        = trial >= {1'b0, ow_div};
  assign trial_sub = trial - {1'b0, ow_div};

  // commit step
  logic [SideW:0] row_sum;
  logic [mcbc_pkg::SpentW-1:0] spent_n;
  assign row_sum = {1'b0, row_wide} + {1'b0, take_q};
  assign spent_n = spent_q + mcbc_pkg::SpentW'(cost_q);

  logic [RowW+mcbc_pkg::RowOutW-1:0] row_ext;
  assign row_ext = (RowW + mcbc_pkg::RowOutW)'(row_q);

  assign status_o.lvl_ok   = lvl_q < levels;
  assign status_o.need_div = !over && (remain < mcbc_pkg::BudgetW'(prod_q));
  assign status_o.div_last = cnt_q == CntLast;
  assign status_o.walk_end = spent_n >= {1'b0, budget_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= '0;
      src_h_q <= '0;
      lvl_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.res_load;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mcbc_pkg::RegSrcWidth:  src_w_q <= cfg_data_i;
          mcbc_pkg::RegSrcHeight: src_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && (op_i == mcbc_pkg::OpReset)) begin
        lvl_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.commit) begin
        if (row_sum >= {1'b0, oh_q}) begin
          lvl_q <= lvl_q + 1'b1;
          row_q <= '0;
        end else begin
          row_q <= row_sum[RowW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      budget_q <= budget_pixels_i;
      spent_q  <= '0;
    end
    if (cmd_i.setup) begin
      ow_q   <= ow;
      oh_q   <= oh;
      left_q <= left;
      area_q <= lw * lh;
    end
    if (cmd_i.area) begin
      if (row_q == '0) begin
        spent_q <= spent_q + mcbc_pkg::SpentW'(area_q);
      end
      prod_q <= left_q * ow_div;
    end
    if (cmd_i.cmp) begin
      // quotient stays below left, so the top dividend bits sit below ow
      rem_q <= remain[mcbc_pkg::ProdW-1:SideW];
      dvd_q <= remain[SideW-1:0];
      cnt_q <= '0;
      if (over) begin
        take_q <= (left_q != '0) ? SideW'(1) : '0;
      end else begin
        take_q <= left_q;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[SideW-1:0] : trial[SideW-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[SideW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.qsel) begin
      take_q <= (quo_q == '0) ? SideW'(1) : quo_q;
    end
    if (cmd_i.apply) begin
      cost_q <= take_q * ow_q;
    end
    if (cmd_i.commit) begin
      spent_q <= spent_n;
    end
    if (cmd_i.res_load) begin
      lvl_out_q   <= lvl_q;
      row_out_q   <= row_ext[mcbc_pkg::RowOutW-1:0];
      wr_q        <= lvl_q < levels;
      spent_out_q <= spent_q[mcbc_pkg::SpentW-1] ? '1 : spent_q[mcbc_pkg::BudgetW-1:0];
    end
  end

  assign done_o         = done_q;
  assign level_index_o  = lvl_out_q;
  assign row_index_o    = row_out_q;
  assign work_remains_o = wr_q;
  assign pixels_spent_o = spent_out_q;

endmodule

[hw/rtl/mip_chain_budget_cursor.sv]
// Top level of the mip chain budget cursor: controller plus datapath.
// A reset item goes straight to its result; an advance works level step by level step,
//   running the divider for each step whose budget covers only part of a level.
// Throughput: one item at a time; a new item is taken in the cycle done_o is high.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// Reset (rst_ni low, async) clears the cursor, the size registers and the sequencer.
module mip_chain_budget_cursor #(
  parameter int unsigned MAX_DIMENSION  = mcbc_pkg::DefaultMaxDimension,
  parameter int unsigned MIN_LEVEL_SIDE = mcbc_pkg::DefaultMinLevelSide
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcbc_pkg::SideW-1:0]    cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [mcbc_pkg::BudgetW-1:0]  budget_pixels_i,
  output logic                          done_o,
  output logic [mcbc_pkg::LvlW-1:0]     level_index_o,
  output logic [mcbc_pkg::RowOutW-1:0]  row_index_o,
  output logic                          work_remains_o,
  output logic [mcbc_pkg::BudgetW-1:0]  pixels_spent_o
);

  mcbc_pkg::cmd_t    cmd;
  mcbc_pkg::status_t status;

  mcbc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mcbc_datapath #(
    .MAX_DIMENSION  (MAX_DIMENSION),
    .MIN_LEVEL_SIDE (MIN_LEVEL_SIDE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .budget_pixels_i (budget_pixels_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .done_o          (done_o),
    .level_index_o   (level_index_o),
    .row_index_o     (row_index_o),
    .work_remains_o  (work_remains_o),
    .pixels_spent_o  (pixels_spent_o)
  );

endmodule

[hw/rtl/mcbc_checker.sv]
// Port-level checks for the mip chain budget cursor, bound to the top level.
module mcbc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          op_i,
  input logic                          done_o,
  input logic [mcbc_pkg::LvlW-1:0]     level_index_o,
  input logic [mcbc_pkg::RowOutW-1:0]  row_index_o,
  input logic [mcbc_pkg::BudgetW-1:0]  pixels_spent_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an item was accepted");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a reset item returns the cursor to the start and charges nothing
  a_reset_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (op_i == mcbc_pkg::OpReset) |=> ##1 (done_o &&
      level_index_o == '0 && row_index_o == '0 && pixels_spent_o == '0))
    else $error("reset item result wrong");

endmodule

bind mip_chain_budget_cursor mcbc_checker u_mcbc_checker (.*);
